@@ src/ppzb_pkg.sv @@
// Shared types and constants of the z-buffered point projection block.
package ppzb_pkg;

  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] RegFocalX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegFocalY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegCenterX = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegCenterY = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegNear = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegFar = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegWidth = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegHeight = 3'd7;

  localparam logic [2:0] StBehind = 3'd0;
  localparam logic [2:0] StOffImage = 3'd1;
  localparam logic [2:0] StDepthWin = 3'd2;
  localparam logic [2:0] StOccluded = 3'd3;
  localparam logic [2:0] StStored = 3'd4;
  localparam logic [2:0] StRead = 3'd5;

  // Quotient width: 64-bit dividend over a 31-bit positive divisor.
  localparam int unsigned ProdBits = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_CHECK,
    S_CLEAR,
    S_ACCESS,
    S_WRITE
  } state_e;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

@@ src/ppzb_div.sv @@
// Restoring divider that forms two floored, saturated quotients one bit a cycle.
module ppzb_div
  import ppzb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctrl_t           ctrl_i,
  input  logic [ProdBits-1:0] prod_a_i,
  input  logic                neg_a_i,
  input  logic [ProdBits-1:0] prod_b_i,
  input  logic                neg_b_i,
  input  logic [30:0]         den_i,
  output div_stat_t           stat_o,
  output logic signed [33:0]  quot_a_o,
  output logic signed [33:0]  quot_b_o
);

  logic [ProdBits-1:0] num_a_q, num_a_d, num_b_q, num_b_d;
  logic [31:0]         rem_a_q, rem_a_d, rem_b_q, rem_b_d;
  logic [30:0]         den_q;
  logic                neg_a_q, neg_b_q;
  logic [6:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [31:0]         tr_a, tr_b;
  logic [32:0]         sub_a, sub_b;

  always_comb begin
    tr_a = {rem_a_q[30:0], num_a_q[ProdBits-1]};
    tr_b = {rem_b_q[30:0], num_b_q[ProdBits-1]};
    sub_a = {1'b0, tr_a} - {2'b0, den_q};
    sub_b = {1'b0, tr_b} - {2'b0, den_q};
    rem_a_d = sub_a[32] ? tr_a : sub_a[31:0];
    rem_b_d = sub_b[32] ? tr_b : sub_b[31:0];
    num_a_d = {num_a_q[ProdBits-2:0], ~sub_a[32]};
    num_b_d = {num_b_q[ProdBits-2:0], ~sub_b[32]};
    busy_d = busy_q;
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(ProdBits - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      num_a_q <= prod_a_i;
      num_b_q <= prod_b_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
      den_q <= den_i;
      neg_a_q <= neg_a_i;
      neg_b_q <= neg_b_i;
    end else if (busy_q) begin
      num_a_q <= num_a_d;
      num_b_q <= num_b_d;
      rem_a_q <= rem_a_d;
      rem_b_q <= rem_b_d;
    end
  end

  assign stat_o.done = busy_q && (cnt_q == 7'(ProdBits - 1));

  // Negative operands round away from zero in magnitude, giving floor.
  function automatic logic signed [33:0] fix(input logic [ProdBits-1:0] q,
                                             input logic nz, input logic ng);
    logic [ProdBits:0] m;
    m = {1'b0, q} + {{ProdBits{1'b0}}, (ng && nz)};
    if (!ng) fix = (m > 65'h1_FFFF_FFFF) ? 34'sh1_FFFF_FFFF : $signed({1'b0, m[32:0]});
    else if (m > 65'h2_0000_0000) fix = -34'sh2_0000_0000;
    else fix = -$signed(m[33:0]);
  endfunction

  assign quot_a_o = fix(num_a_q, |rem_a_q, neg_a_q);
  assign quot_b_o = fix(num_b_q, |rem_b_q, neg_b_q);

endmodule

@@ src/ppzb_store.sv @@
// Per-pixel memory of depth, index and valid bit, with registered read data.
module ppzb_store
  import ppzb_pkg::*;
#(
  parameter int unsigned AddrBits = 17,
  parameter int unsigned IndexBits = 20
) (
  input  logic                 clk_i,
  input  logic [AddrBits-1:0]  rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AddrBits-1:0]  wr_addr_i,
  input  logic [31:0]          wr_depth_i,
  input  logic [IndexBits-1:0] wr_index_i,
  input  logic                 wr_valid_i,
  output logic [31:0]          rd_depth_o,
  output logic [IndexBits-1:0] rd_index_o,
  output logic                 rd_valid_o
);

  localparam int unsigned Entries = 1 << AddrBits;
  localparam int unsigned Width = 33 + IndexBits;

  logic [Width-1:0] mem_q [Entries];
  logic [Width-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= {wr_valid_i, wr_depth_i, wr_index_i};
    rd_q <= mem_q[rd_addr_i];
  end

  assign {rd_valid_o, rd_depth_o, rd_index_o} = rd_q;

endmodule

@@ src/point_projection_z_buffer.sv @@
// Top level of the z-buffered point projection block.
//
// A request is taken when start_i is high and busy_o is low; each request
// yields exactly one result, shown for one cycle with done_o high, and the
// receiver cannot stall it. A point behind the camera is answered in the
// cycle after it is taken and does not raise busy_o. A read request holds
// busy_o through S_ACCESS (memory read) and S_WRITE (write-back of the
// cleared entry), and its result shows in the cycle after S_WRITE, in which
// the next request may already be taken. A project request first forms two
// 32x32 products, then the restoring divider produces both quotients one bit
// a cycle; a point that falls off the image or outside the depth window is
// answered from S_CHECK, and one that reaches the pixel memory holds busy_o
// on through S_ACCESS and S_WRITE while the entry is read, compared and
// written back. Its result shows in the first cycle in which busy_o is low
// again. After reset the block sweeps the whole pixel memory once to mark
// every entry empty, one entry a cycle, and holds busy_o high until then;
// configuration writes are taken throughout.
module point_projection_z_buffer
  import ppzb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 512,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned INDEX_BITS = 20,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  op_i,
  input  logic signed [31:0]    point_x_i,
  input  logic signed [31:0]    point_y_i,
  input  logic signed [31:0]    point_z_i,
  input  logic [19:0]           point_index_i,
  input  logic [8:0]            read_column_i,
  input  logic [7:0]            read_row_i,
  output logic                  done_o,
  output logic [2:0]            status_o,
  output logic                  visible_o,
  output logic [19:0]           visible_index_o,
  output logic [31:0]           visible_depth_o,
  output logic [8:0]            hit_column_o,
  output logic [7:0]            hit_row_o
);

  localparam int unsigned ColBits = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits = $clog2(MAX_HEIGHT);
  localparam int unsigned AddrBits = ColBits + RowBits;
  localparam int unsigned IdxKeep = (INDEX_BITS < 20) ? INDEX_BITS : 20;

  // Configuration registers.
  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [30:0] near_q, far_q;
  logic [9:0]  width_q;
  logic [8:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= 32'd6598947;
      focal_y_q <= 32'd6598947;
      center_x_q <= 32'd10485760;
      center_y_q <= 32'd7864320;
      near_q <= 31'd6554;
      far_q <= 31'd655360;
      width_q <= 10'd320;
      height_q <= 9'd240;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegFocalX: focal_x_q <= cfg_data_i;
        RegFocalY: focal_y_q <= cfg_data_i;
        RegCenterX: center_x_q <= cfg_data_i;
        RegCenterY: center_y_q <= cfg_data_i;
        RegNear: near_q <= cfg_data_i[30:0];
        RegFar: far_q <= cfg_data_i[30:0];
        RegWidth: width_q <= cfg_data_i[9:0];
        RegHeight: height_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [AddrBits-1:0] clr_q;
  logic op_q;
  logic [30:0] z_q;
  logic [IdxKeep-1:0] idx_q;
  logic [AddrBits-1:0] addr_q;
  logic oob_q;
  logic [8:0] col_q;
  logic [7:0] row_q;
  logic [ProdBits-1:0] prod_x_q, prod_y_q;
  logic neg_x_q, neg_y_q;
  logic mul_q;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  logic signed [33:0] qx, qy;

  logic [31:0] rd_depth;
  logic [INDEX_BITS-1:0] rd_index;
  logic rd_valid;
  logic wr_en, wr_valid;
  logic [AddrBits-1:0] wr_addr, rd_addr;
  logic [31:0] wr_depth;
  logic [INDEX_BITS-1:0] wr_index;

  logic [31:0] mag_x, mag_y;

  logic take;
  assign take = start_i && !busy_o;

  // Magnitudes of the coordinates; the most negative value becomes 2^31.
  assign mag_x = point_x_i[31] ? 32'(-point_x_i) : 32'(point_x_i);
  assign mag_y = point_y_i[31] ? 32'(-point_y_i) : 32'(point_y_i);

  // Projection decision from the finished quotients.
  logic signed [34:0] u, v;
  logic [31:0] w_use;
  logic [31:0] h_use;
  logic off_img, win_bad;
  logic [34-FRAC_BITS:0] pcol, prow;
  always_comb begin
    u = 35'(qx) + $signed({3'b0, center_x_q});
    v = 35'(qy) + $signed({3'b0, center_y_q});
    w_use = (32'(width_q) < MAX_WIDTH) ? 32'(width_q) : MAX_WIDTH;
    h_use = (32'(height_q) < MAX_HEIGHT) ? 32'(height_q) : MAX_HEIGHT;
    pcol = u[34:FRAC_BITS];
    prow = v[34:FRAC_BITS];
    off_img = u[34] || v[34] || (32'(pcol) >= w_use) || (32'(prow) >= h_use);
    win_bad = (z_q < near_q) || (z_q > far_q);
  end

  logic [2:0] res_status_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE: begin
        if (take) begin
          if (op_i) state_d = S_ACCESS;
          else if (point_z_i <= 0) state_d = S_IDLE;
          else state_d = S_DIVIDE;
        end
      end
      S_DIVIDE: if (div_stat.done) state_d = S_CHECK;
      S_CHECK: state_d = (off_img || win_bad) ? S_IDLE : S_ACCESS;
      S_ACCESS: state_d = S_WRITE;
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      mul_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mul_q <= take && !op_i && (point_z_i > 0);
      if (state_q == S_CLEAR) clr_q <= clr_q + AddrBits'(1);
    end
  end

  // Request capture and the products (one 32x32 multiply each, registered).
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q <= op_i;
      z_q <= point_z_i[30:0];
      idx_q <= point_index_i[IdxKeep-1:0];
      neg_x_q <= point_x_i[31];
      neg_y_q <= point_y_i[31];
      prod_x_q <= 64'(mag_x) * 64'(focal_x_q);
      prod_y_q <= 64'(mag_y) * 64'(focal_y_q);
      oob_q <= (32'(read_column_i) >= MAX_WIDTH) || (32'(read_row_i) >= MAX_HEIGHT);
      col_q <= read_column_i;
      row_q <= read_row_i;
      addr_q <= {RowBits'(read_row_i), ColBits'(read_column_i)};
    end else if (state_q == S_CHECK) begin
      col_q <= 9'(pcol);
      row_q <= 8'(prow);
      addr_q <= {RowBits'(prow), ColBits'(pcol)};
      oob_q <= 1'b0;
    end
  end

  assign div_ctrl.start = mul_q;

  ppzb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .prod_a_i(prod_x_q),
    .neg_a_i (neg_x_q),
    .prod_b_i(prod_y_q),
    .neg_b_i (neg_y_q),
    .den_i   (z_q),
    .stat_o  (div_stat),
    .quot_a_o(qx),
    .quot_b_o(qy)
  );

  // Memory read in S_ACCESS settles for S_WRITE; one request at a time, so
  // no forwarding is needed.
  assign rd_addr = addr_q;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = addr_q;
    wr_depth = 32'hFFFF_FFFF;
    wr_index = rd_index;
    wr_valid = 1'b0;
    res_status_d = StRead;
    if (state_q == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = clr_q;
    end else if (state_q == S_WRITE) begin
      if (op_q) begin
        wr_en = !oob_q;
      end else if ({1'b0, z_q} < rd_depth) begin
        wr_en = 1'b1;
        wr_depth = {1'b0, z_q};
        wr_index = INDEX_BITS'(idx_q);
        wr_valid = 1'b1;
        res_status_d = StStored;
      end else begin
        res_status_d = StOccluded;
      end
    end
  end

  ppzb_store #(.AddrBits(AddrBits), .IndexBits(INDEX_BITS)) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_depth_i(wr_depth),
    .wr_index_i(wr_index),
    .wr_valid_i(wr_valid),
    .rd_depth_o(rd_depth),
    .rd_index_o(rd_index),
    .rd_valid_o(rd_valid)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= (take && !op_i && (point_z_i <= 0))
                   || (state_q == S_CHECK && (off_img || win_bad))
                   || (state_q == S_WRITE);
  end

  logic [2:0]  status_d;
  logic        visible_d;
  logic [19:0] vindex_d;
  logic [31:0] vdepth_d;
  logic [8:0]  hcol_d;
  logic [7:0]  hrow_d;

  always_comb begin
    status_d = StBehind;
    visible_d = 1'b0;
    vindex_d = '0;
    vdepth_d = '0;
    hcol_d = '0;
    hrow_d = '0;
    if (state_q == S_CHECK) begin
      if (off_img) status_d = StOffImage;
      else begin
        status_d = StDepthWin;
        hcol_d = 9'(pcol);
        hrow_d = 8'(prow);
      end
    end else if (state_q == S_WRITE) begin
      status_d = res_status_d;
      if (op_q) begin
        vdepth_d = 32'hFFFF_FFFF;
        if (!oob_q && rd_valid) begin
          visible_d = 1'b1;
          vindex_d = 20'(rd_index);
          vdepth_d = rd_depth;
        end
      end else begin
        hcol_d = col_q;
        hrow_d = row_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_o <= status_d;
    visible_o <= visible_d;
    visible_index_o <= vindex_d;
    visible_depth_o <= vdepth_d;
    hit_column_o <= hcol_d;
    hit_row_o <= hrow_d;
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  a_done_not_taking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> done_o) else $error("missing result after write-back");
  a_clear_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !done_o) else $error("result during clearing pass");
  a_store_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && !op_q && wr_en) |-> ({1'b0, z_q} < rd_depth))
    else $error("store without nearer depth");
`endif

endmodule
